[rtl/probe_cache_clock_replacement_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the probe cache core
// ---------------------------------------------------------------------------
`ifndef PROBE_CACHE_CLOCK_REPLACEMENT_CORE_MACROS_SVH
`define PROBE_CACHE_CLOCK_REPLACEMENT_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define PCC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/pccr_pkg.sv]
// ---------------------------------------------------------------------------
// pccr_pkg
// Types and constants of the probe cache core.
// ---------------------------------------------------------------------------
package pccr_pkg;
  localparam int ENTRIES  = 256;
  localparam int KEY_BITS = 64;
  localparam int IDX_W    = $clog2(ENTRIES);

  localparam logic [1:0] ACT_LOOKUP  = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_CANCEL  = 2'd2;
  localparam logic [1:0] ACT_STATUS  = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] probe_hash;
    logic [63:0] probe_key;
    logic [15:0] request_tag;
    logic [7:0]  entry_index;
    logic [1:0]  resp_status;
  } in_word_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  slot;
    logic        no_victim;
    logic        cancel_child;
    logic [15:0] cancel_tag;
    logic [1:0]  entry_status;
  } out_word_t;

  // broadcast from controller to all cells
  typedef struct packed {
    logic                match_en;
    logic                hit_wr;
    logic                claim_wr;
    logic                rel_wr;
    logic                cancel_wr;
    logic                status_wr;
    logic [IDX_W-1:0]    sel;
    logic [31:0]         hash;
    logic [KEY_BITS-1:0] key;
    logic [15:0]         tag;
    logic [1:0]          rstat;
  } cell_cmd_t;

  typedef struct packed {
    logic        match;
    logic        free;
    logic        valid;
    logic        pinned;
    logic        use_b;
    logic        pend;
    logic [15:0] count;
    logic [15:0] tag;
    logic [1:0]  status;
  } cell_stat_t;
endpackage

[rtl/pccr_cell.sv]
// ---------------------------------------------------------------------------
// pccr_cell
// One cache entry: key, hash, count, flags; clears its use bit as the hand passes.
// ---------------------------------------------------------------------------
module pccr_cell
  import pccr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_cmd_t  cmd,
  input  logic       me,
  input  logic       clr_use,
  output cell_stat_t stat
);
  logic                valid_r, use_r, pend_r;
  logic [15:0]         count_r, tag_r;
  logic [1:0]          status_r;
  logic [31:0]         hash_r;
  logic [KEY_BITS-1:0] key_r;

  assign stat.match  = cmd.match_en && valid_r && !pend_r && hash_r == cmd.hash
                       && key_r == cmd.key;
  assign stat.free   = count_r == 16'd0;
  assign stat.valid  = valid_r;
  assign stat.pinned = count_r != 16'd0;
  assign stat.use_b  = use_r;
  assign stat.pend   = pend_r;
  assign stat.count  = count_r;
  assign stat.tag    = tag_r;
  assign stat.status = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      use_r    <= 1'b0;
      pend_r   <= 1'b0;
      count_r  <= '0;
      status_r <= '0;
    end else begin
      if (clr_use) use_r <= 1'b0;
      if (me) begin
        if (cmd.hit_wr) begin
          use_r <= 1'b1;
          if (count_r != 16'hFFFF) count_r <= count_r + 16'd1;
        end
        if (cmd.claim_wr) begin
          valid_r  <= 1'b1;
          use_r    <= 1'b1;
          pend_r   <= 1'b0;
          count_r  <= 16'd1;
          status_r <= '0;
          hash_r   <= cmd.hash;
          key_r    <= cmd.key;
          tag_r    <= cmd.tag;
        end
        if (cmd.rel_wr) count_r <= count_r - 16'd1;
        if (cmd.cancel_wr) begin
          count_r <= count_r - 16'd1;
          if (count_r == 16'd1 && status_r == 2'd0) pend_r <= 1'b1;
        end
        if (cmd.status_wr) status_r <= cmd.rstat;
      end
    end
  end
endmodule

[rtl/pccr_array.sv]
// ---------------------------------------------------------------------------
// pccr_array
// Row of entry cells with a registered hit encoder and a reader mux.
// ---------------------------------------------------------------------------
module pccr_array
  import pccr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_cmd_t        cmd,
  input  logic             hand_clr,
  output logic             any_hit,
  output logic [IDX_W-1:0] hit_idx,
  output logic             any_free,
  output cell_stat_t       sel_stat
);
  cell_stat_t st [ENTRIES];
  logic [ENTRIES-1:0] mv, fv;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    pccr_cell u_cell (
      .clk(clk), .rst_n(rst_n), .cmd(cmd),
      .me(cmd.sel == IDX_W'(g)),
      .clr_use(hand_clr && cmd.sel == IDX_W'(g)),
      .stat(st[g])
    );
    assign mv[g] = st[g].match;
    assign fv[g] = st[g].free;
  end

  // first match, registered
  always_ff @(posedge clk) begin
    any_hit <= |mv;
    any_free <= |fv;
    hit_idx <= '0;
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (mv[i]) hit_idx <= IDX_W'(i);
  end

  assign sel_stat = st[cmd.sel];
endmodule

[rtl/probe_cache_clock_replacement_core.sv]
// ---------------------------------------------------------------------------
// probe_cache_clock_replacement_core
// Probe cache with reference counts and clock second-chance replacement.
// Lookup hit: result from S_DEC, after S_MATCH.
// Miss: hand walk clears use bits, claims an unpinned entry with no use bit.
// Release, cancel, status: S_ACT. Next word is taken in the result cycle.
// Result strobe is one cycle; no stall. Reset clears flags, counts, the hand.
// ---------------------------------------------------------------------------
module probe_cache_clock_replacement_core
  import pccr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);
  `include "probe_cache_clock_replacement_core_macros.svh"

  typedef enum logic [2:0] {S_IDLE, S_MATCH, S_DEC, S_HAND, S_ACT} state_t;
  state_t           state_r;
  in_word_t         req_r;
  logic [IDX_W-1:0] hand_r;
  cell_cmd_t        cmd;
  logic             any_hit, any_free, hand_clr;
  logic [IDX_W-1:0] hit_idx;
  cell_stat_t       ss;

  pccr_array u_array (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .hand_clr(hand_clr),
    .any_hit(any_hit), .hit_idx(hit_idx), .any_free(any_free), .sel_stat(ss)
  );

  assign busy = state_r != S_IDLE;
  logic idx_ok;
  assign idx_ok = 32'(req_r.entry_index) < ENTRIES;

  always_comb begin
    cmd = '0;
    cmd.hash  = req_r.probe_hash;
    cmd.key   = req_r.probe_key[KEY_BITS-1:0];
    cmd.tag   = req_r.request_tag;
    cmd.rstat = req_r.resp_status;
    cmd.sel   = req_r.entry_index[IDX_W-1:0];
    cmd.match_en = state_r == S_MATCH;
    hand_clr = 1'b0;
    if (state_r == S_HAND) begin
      cmd.sel = hand_r;
      cmd.claim_wr = !ss.pinned && !ss.use_b;
      hand_clr = !ss.pinned && ss.use_b;
    end
    if (state_r == S_DEC && req_r.action == ACT_LOOKUP) begin
      cmd.sel = hit_idx;
      cmd.hit_wr = any_hit;
    end
    if (state_r == S_ACT && idx_ok && ss.valid) begin
      cmd.status_wr = req_r.action == ACT_STATUS;
      cmd.rel_wr    = req_r.action == ACT_RELEASE && ss.pinned;
      cmd.cancel_wr = req_r.action == ACT_CANCEL && ss.pinned;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      hand_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (start) begin
          req_r   <= in_word;
          state_r <= (in_word.action == ACT_LOOKUP) ? S_MATCH : S_ACT;
        end
        S_MATCH: state_r <= S_DEC;
        S_DEC: begin
          out_word <= '0;
          if (any_hit) begin
            out_valid <= 1'b1;
            out_word.hit <= 1'b1;
            out_word.slot <= 8'(hit_idx);
            out_word.entry_status <= ss.status;
            state_r <= S_IDLE;
          end else if (!any_free) begin
            out_valid <= 1'b1;
            out_word.no_victim <= 1'b1;
            state_r <= S_IDLE;
          end else state_r <= S_HAND;
        end
        S_HAND: begin
          hand_r <= (32'(hand_r) + 1 >= ENTRIES) ? '0 : hand_r + 1'b1;
          if (cmd.claim_wr) begin
            out_valid <= 1'b1;
            out_word  <= '0;
            out_word.slot <= 8'(hand_r);
            state_r <= S_IDLE;
          end
        end
        S_ACT: begin
          out_valid <= 1'b1;
          out_word  <= '0;
          if (idx_ok && ss.valid) begin
            if (req_r.action == ACT_STATUS) out_word.entry_status <= req_r.resp_status;
            else begin
              out_word.entry_status <= ss.status;
              if (cmd.cancel_wr && ss.count == 16'd1 && ss.status == 2'd0) begin
                out_word.cancel_child <= 1'b1;
                out_word.cancel_tag <= ss.tag;
              end
            end
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `PCC_ASSERT_IMP(a_out_idle, clk, rst_n, out_valid, state_r == S_IDLE, "out while busy")
  `PCC_ASSERT_NXT(a_out_single, clk, rst_n, out_valid, !out_valid, "out twice")
  `PCC_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept")
  `PCC_ASSERT_IMP(a_claim_free, clk, rst_n, cmd.claim_wr, !ss.pinned, "claim pinned")
endmodule
